### hw/rtl/pbrc_pkg.sv
package pbrc_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 20;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int TOTAL_W = $clog2(MAX_POINTS + 1);
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    point_t lo;
    point_t hi;
  } box_t;

  typedef struct packed {
    logic load;
    logic step;
    logic valid;
    logic last;
  } match_ctl_t;

endpackage

### hw/rtl/pbrc_cell.sv
module pbrc_cell
  import pbrc_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  point_t point_in,
  output point_t point_out
);

  point_t point;

  always_ff @(posedge clk) begin
    if (shift) begin
      point <= point_in;
    end
  end

  assign point_out = point;

endmodule

### hw/rtl/pbrc_match.sv
module pbrc_match
  import pbrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  match_ctl_t         ctl,
  input  box_t               box_in,
  input  point_t             point_in,
  input  logic               flag_in,
  output logic               done,
  output logic [COUNT_W-1:0] inside_count,
  output logic               overflowed
);

  box_t               box;
  logic [COUNT_W-1:0] count;
  logic               hit;
  logic               hit_v;
  logic               last1;
  logic               in_box;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] count_next;

  assign in_box = (point_in.x >= box.lo.x) && (point_in.x <= box.hi.x) &&
                  (point_in.y >= box.lo.y) && (point_in.y <= box.hi.y) &&
                  (point_in.z >= box.lo.z) && (point_in.z <= box.hi.z);

  assign sum = {1'b0, count} + {{COUNT_W{1'b0}}, hit};
  assign count_next = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      box <= box_in;
    end
    hit <= ctl.valid && in_box;
    if (ctl.load) begin
      count <= '0;
    end else if (hit_v) begin
      count <= count_next;
    end
    if (last1) begin
      inside_count <= count_next;
      overflowed <= flag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_v <= 1'b0;
      last1 <= 1'b0;
      done <= 1'b0;
    end else begin
      hit_v <= ctl.step;
      last1 <= ctl.step && ctl.last;
      done <= last1;
    end
  end

endmodule

### hw/rtl/point_box_range_counter_top.sv
// Channel  Direction  Handshake                  Payload
// input    in         start high while busy low  mode, x/y/z_low, x/y/z_high
// result   out        done high for one cycle    inside_count, overflowed
//
// Points live in a ring of MAX_POINTS cells, newest point at the head.
// An insert is never held off by busy beyond a query.
// A query rotates the ring once past a comparator and holds busy until the
// result is out; done rises in the last busy cycle.
// Reset empties the store and clears the overflow flag.
// The receiver cannot stall: each result is shown for exactly one cycle.
module point_box_range_counter_top
  import pbrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  coord_t             x_low,
  input  coord_t             y_low,
  input  coord_t             z_low,
  input  coord_t             x_high,
  input  coord_t             y_high,
  input  coord_t             z_high,
  output logic               done,
  output logic [COUNT_W-1:0] inside_count,
  output logic               overflowed
);

  point_t             chain [MAX_POINTS+1];
  logic               rot;
  logic [IDX_W-1:0]   k;
  logic [TOTAL_W-1:0] thr;
  logic [TOTAL_W-1:0] total;
  logic               drop;
  logic               accept;
  logic               do_insert;
  logic               full;
  logic               shift;
  point_t             new_point;
  box_t               box_in;
  match_ctl_t         ctl;

  assign accept = start && !busy;
  assign full = (total == TOTAL_W'(MAX_POINTS));
  assign do_insert = accept && (mode == MODE_INSERT) && !full;
  assign shift = rot || do_insert;

  assign new_point = '{x: x_low, y: y_low, z: z_low};
  assign box_in = '{lo: new_point, hi: '{x: x_high, y: y_high, z: z_high}};

  assign chain[0] = rot ? chain[MAX_POINTS] : new_point;

  genvar i;
  generate
    for (i = 0; i < MAX_POINTS; i++) begin : g_cell
      pbrc_cell u_cell (
        .clk       (clk),
        .shift     (shift),
        .point_in  (chain[i]),
        .point_out (chain[i+1])
      );
    end
  endgenerate

  assign ctl.load = accept && (mode == MODE_QUERY);
  assign ctl.step = rot;
  assign ctl.valid = rot && ({1'b0, k} >= thr);
  assign ctl.last = (k == IDX_W'(MAX_POINTS - 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      thr <= TOTAL_W'(MAX_POINTS) - total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rot <= 1'b0;
      k <= '0;
      total <= '0;
      drop <= 1'b0;
    end else begin
      if (ctl.load) begin
        busy <= 1'b1;
        rot <= 1'b1;
        k <= '0;
      end else if (rot) begin
        k <= k + 1'b1;
        if (ctl.last) begin
          rot <= 1'b0;
        end
      end else if (done) begin
        busy <= 1'b0;
      end
      if (do_insert) begin
        total <= total + 1'b1;
      end
      if (accept && (mode == MODE_INSERT) && full) begin
        drop <= 1'b1;
      end
    end
  end

  pbrc_match u_match (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .box_in       (box_in),
    .point_in     (chain[MAX_POINTS]),
    .flag_in      (drop),
    .done         (done),
    .inside_count (inside_count),
    .overflowed   (overflowed)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result issued outside a query");

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= MAX_POINTS)
    else $error("point total above capacity");

  a_count_le_total: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(inside_count) <= 32'(total))
    else $error("count above stored points");

  a_no_shift_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && !rot) |-> !shift)
    else $error("ring moved while a query drains");

  a_drop_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(drop) |-> $past(full))
    else $error("overflow flag set with room left");

endmodule

### tb/sv/point_box_range_counter_top_tb.sv
`timescale 1ns / 1ps

module point_box_range_counter_top_tb;
  import pbrc_pkg::*;

  localparam coord_t CMAX = '1;
  localparam int WATCHDOG_LIMIT = 4 * (MAX_POINTS + 2) + 200;
  localparam int RANDOM_ITEMS = 1150;
  localparam int QUERY_PCT = 15;
  localparam int IDLE_PCT = 26;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic mode;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    logic typed;
    logic [COUNT_W-1:0] want_count;
    logic want_ovf;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic ovf;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cur = '0;
  logic busy;
  logic done;
  logic [COUNT_W-1:0] inside_count;
  logic overflowed;

  coord_t stored_x [MAX_POINTS];
  coord_t stored_y [MAX_POINTS];
  coord_t stored_z [MAX_POINTS];
  int unsigned stored_total = 0;
  bit dropped_any = 1'b0;
  answer_t pending_answers [$];
  int mismatches = 0;
  int stall_cycles = 0;

  point_box_range_counter_top u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(cur.mode),
    .x_low(cur.lo[0]),
    .y_low(cur.lo[1]),
    .z_low(cur.lo[2]),
    .x_high(cur.hi[0]),
    .y_high(cur.hi[1]),
    .z_high(cur.hi[2]),
    .done(done),
    .inside_count(inside_count),
    .overflowed(overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic cmd_t row(logic m, coord_t xl, coord_t yl, coord_t zl, coord_t xh,
                               coord_t yh, coord_t zh, logic t, int cnt, logic ovf);
    cmd_t c;
    c.mode = m;
    c.lo = {zl, yl, xl};
    c.hi = {zh, yh, xh};
    c.typed = t;
    c.want_count = cnt[COUNT_W-1:0];
    c.want_ovf = ovf;
    return c;
  endfunction

  function automatic coord_t rand_coord(int style);
    case (style)
      0: return coord_t'($urandom_range(0, 15));
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return coord_t'(1);
          2: return CMAX - 1;
          3: return CMAX;
          default: return coord_t'($urandom);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic cmd_t rand_item(int query_pct, bit force_insert);
    cmd_t c;
    int r;
    int style;
    coord_t a;
    coord_t b;
    c = '0;
    r = $urandom_range(0, 99);
    style = (r < 55) ? 0 : (r < 70) ? 1 : 2;
    c.mode = (!force_insert && $urandom_range(0, 99) < query_pct) ? MODE_QUERY : MODE_INSERT;
    for (int ax = 0; ax < 3; ax++) begin
      a = rand_coord(style);
      b = rand_coord(style);
      if (c.mode == MODE_QUERY) begin
        if ($urandom_range(0, 99) < 15) begin
          a = '0;
          b = CMAX;
        end else if ($urandom_range(0, 99) < 85 && a > b) begin
          a = a ^ b;
          b = a ^ b;
          a = a ^ b;
        end
      end
      c.lo[ax] = a;
      c.hi[ax] = b;
    end
    return c;
  endfunction

  task automatic report(string what, int want, int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic issue(cmd_t c, bit pauses);
    while (pauses && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cur <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Tracks accepted transactions, predicts each answer and checks the results.
  always @(posedge clk) begin
    answer_t want;
    int unsigned hits;
    bit progress;
    if (rst) begin
      stored_total = 0;
      dropped_any = 1'b0;
      stall_cycles = 0;
    end else begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        if (pending_answers.size() == 0) begin
          report("unexpected result count", -1, inside_count);
        end else begin
          want = pending_answers.pop_front();
          if (inside_count !== want.count) report("inside_count", want.count, inside_count);
          if (overflowed !== want.ovf) report("overflowed", want.ovf, overflowed);
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        if (cur.mode == MODE_INSERT) begin
          if (stored_total < MAX_POINTS) begin
            stored_x[stored_total] = cur.lo[0];
            stored_y[stored_total] = cur.lo[1];
            stored_z[stored_total] = cur.lo[2];
            stored_total++;
          end else begin
            dropped_any = 1'b1;
          end
        end else begin
          hits = 0;
          for (int unsigned i = 0; i < stored_total; i++) begin
            if (stored_x[i] >= cur.lo[0] && stored_x[i] <= cur.hi[0] &&
                stored_y[i] >= cur.lo[1] && stored_y[i] <= cur.hi[1] &&
                stored_z[i] >= cur.lo[2] && stored_z[i] <= cur.hi[2]) begin
              hits++;
            end
          end
          if (hits > COUNT_MAX) hits = COUNT_MAX;
          want.count = hits[COUNT_W-1:0];
          want.ovf = dropped_any;
          if (cur.typed) begin
            want.count = cur.want_count;
            want.ovf = cur.want_ovf;
          end
          pending_answers.push_back(want);
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    cmd_t directed [$];
    directed.push_back(row(MODE_QUERY, 0, 0, 0, CMAX, CMAX, CMAX, 1, 0, 0));
    directed.push_back(row(MODE_QUERY, CMAX, CMAX, CMAX, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(MODE_INSERT, 0, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0));
    directed.push_back(row(MODE_INSERT, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(MODE_INSERT, 0, CMAX, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(MODE_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(MODE_QUERY, 0, 0, 0, CMAX, CMAX, CMAX, 1, 4, 0));
    directed.push_back(row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 2, 0));
    directed.push_back(row(MODE_QUERY, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1, 0));
    directed.push_back(row(MODE_QUERY, 1, 0, 0, 0, CMAX, CMAX, 1, 0, 0));
    directed.push_back(row(MODE_QUERY, 0, 1, 0, CMAX, 0, CMAX, 1, 0, 0));
    directed.push_back(row(MODE_QUERY, 0, 0, 1, CMAX, CMAX, 0, 1, 0, 0));
    directed.push_back(row(MODE_INSERT, 5, 6, 7, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(MODE_QUERY, 5, 6, 7, 5, 6, 7, 0, 0, 0));
    directed.push_back(row(MODE_QUERY, 1, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0));
    directed.push_back(row(MODE_QUERY, 0, 0, 0, CMAX - 1, CMAX, CMAX, 0, 0, 0));
    directed.push_back(row(MODE_INSERT, 'hAAAAA, 'h55555, 'hAAAAA, 'h55555, 'hAAAAA,
                           'h55555, 0, 0, 0));
    directed.push_back(row(MODE_INSERT, 'h55555, 'hAAAAA, 'h55555, 'hAAAAA, 'h55555,
                           'hAAAAA, 0, 0, 0));
    directed.push_back(row(MODE_QUERY, 'h55555, 'h55555, 'h55555, 'hAAAAA, 'hAAAAA,
                           'hAAAAA, 0, 0, 0));
    directed.push_back(row(MODE_QUERY, 0, 0, CMAX, 0, CMAX, CMAX, 0, 0, 0));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) issue(directed[i], 1'b1);

    // Hold off until every outstanding answer has come back.
    start <= 1'b0;
    @(negedge clk);
    while (pending_answers.size() != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue(rand_item(QUERY_PCT, 1'b0), !(n >= 500 && n < 700));
    end

    // Fill the store to the brim, then push past it so inserts are dropped.
    while (stored_total < MAX_POINTS - 1) issue(rand_item(0, 1'b1), 1'b1);
    issue(row(MODE_QUERY, 0, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0), 1'b1);
    issue(rand_item(0, 1'b1), 1'b1);
    issue(row(MODE_QUERY, 0, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0), 1'b1);
    repeat (3) issue(rand_item(0, 1'b1), 1'b1);
    issue(row(MODE_QUERY, 0, 0, 0, CMAX, CMAX, CMAX, 0, 0, 0), 1'b1);
    issue(rand_item(100, 1'b0), 1'b1);
    issue(rand_item(0, 1'b1), 1'b1);
    issue(rand_item(100, 1'b0), 1'b1);

    start <= 1'b0;
    @(negedge clk);
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (MAX_POINTS + 8) @(negedge clk);

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
